>>> hw/rtl/spo_pkg.sv
// Shared types, widths and helpers for the sphere pair overlap and push block.
// No dependencies; used by sphere_pair_overlap_push_top.
package spo_pkg;

	localparam int CW   = 32;          // coordinate width, signed Q16.16
	localparam int RW   = CW - 1;      // radius width, unsigned Q15.16
	localparam int MW   = CW + 1;      // magnitude of a center difference
	localparam int SQW  = 2 * MW;      // square of one difference
	localparam int DW   = 2 * MW + 2;  // sum of three squares
	localparam int REMW = CW + 1;      // square root partial remainder

	typedef struct packed {
		logic [CW-1:0] center_a_x;
		logic [CW-1:0] center_a_y;
		logic [CW-1:0] center_a_z;
		logic [CW-1:0] center_b_x;
		logic [CW-1:0] center_b_y;
		logic [CW-1:0] center_b_z;
		logic [RW-1:0] radius_a;
		logic [RW-1:0] radius_b;
		logic          trigger_a;
		logic          trigger_b;
		logic          movable_a;
		logic          movable_b;
	} pair_word_t;

	typedef struct packed {
		logic          overlap;
		logic [CW-1:0] shift_a_x;
		logic [CW-1:0] shift_a_y;
		logic [CW-1:0] shift_a_z;
		logic [CW-1:0] shift_b_x;
		logic [CW-1:0] shift_b_y;
		logic [CW-1:0] shift_b_z;
	} result_word_t;

	// Control and operands that ride along the long pipeline.
	typedef struct packed {
		logic                 ovl;
		logic                 act;
		logic                 ma;
		logic                 mb;
		logic [2:0]           neg;
		logic [2:0][CW-1:0]   mag;
		logic [CW-1:0]        rsum;
	} ctl_t;

	// Apply the sign and saturate to the signed coordinate range.
	function automatic logic [CW-1:0] sat_pack(input logic [CW-1:0] mag, input logic neg);
		logic [CW-1:0] lim;
		lim = {1'b1, {(CW-1){1'b0}}};
		if (neg) begin
			sat_pack = (mag > lim) ? lim : (~mag + 1'b1);
		end else begin
			sat_pack = (mag > (lim - 1'b1)) ? (lim - 1'b1) : mag;
		end
	endfunction

endpackage

>>> hw/rtl/sphere_pair_overlap_push_top.sv
// Top level of the sphere pair overlap and push block.
// Depends on spo_pkg for word types, widths and the saturating pack.

// Sphere pair overlap with push-out. Pulse start with a pair word; busy is
// always low, so a new pair may enter on every clock. Each pair yields one
// result word, marked by a one-cycle done strobe, in order of entry. The
// pipeline depth is set by the square root (one root bit per stage, CW
// stages) and the three parallel restoring dividers (one quotient bit per
// stage, CW stages).
// Stages: difference/abs, squares, sum and radius compare, CW root stages,
// push length, push times magnitude, CW divide stages, sign and saturate.
// The receiver cannot hold results off; take done words as they come.
module sphere_pair_overlap_push_top
	import spo_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	output logic         busy,
	input  pair_word_t   pair,
	output logic         done,
	output result_word_t result
);

	typedef struct packed {
		ctl_t          c;
		logic [2*CW-1:0] rad;
		logic [REMW-1:0] rem;
		logic [CW-1:0]   root;
	} sq_t;

	typedef struct packed {
		ctl_t               c;
		logic [CW-1:0]      len;
		logic [2:0][CW-1:0] rem;
		logic [2:0][CW-1:0] num;
		logic [2:0][CW-1:0] q;
	} dv_t;

	assign busy = 1'b0;

	// ---- stage 1: differences, magnitudes, radius sum
	logic [2:0][MW-1:0] mag_s1;
	logic [2:0]         neg_s1;
	logic [CW-1:0]      rsum_s1;
	logic               trig_s1, ma_s1, mb_s1, vld_s1;
	logic [2:0][MW-1:0] d_c;
	logic [2:0][CW-1:0] ca, cb;

	assign ca = {pair.center_a_z, pair.center_a_y, pair.center_a_x};
	assign cb = {pair.center_b_z, pair.center_b_y, pair.center_b_x};

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			d_c[i] = {ca[i][CW-1], ca[i]} - {cb[i][CW-1], cb[i]};
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			neg_s1[i] <= d_c[i][MW-1];
			mag_s1[i] <= d_c[i][MW-1] ? (~d_c[i] + 1'b1) : d_c[i];
		end
		rsum_s1 <= {1'b0, pair.radius_a} + {1'b0, pair.radius_b};
		trig_s1 <= pair.trigger_a | pair.trigger_b;
		ma_s1   <= pair.movable_a;
		mb_s1   <= pair.movable_b;
	end

	// ---- stage 2: squares
	logic [2:0][SQW-1:0] sq_s2;
	logic [2*CW-1:0]     rsq_s2;
	logic [2:0][MW-1:0]  mag_s2;
	logic [2:0]          neg_s2;
	logic [CW-1:0]       rsum_s2;
	logic                trig_s2, ma_s2, mb_s2, vld_s2;

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			sq_s2[i] <= mag_s1[i] * mag_s1[i];
		end
		rsq_s2  <= rsum_s1 * rsum_s1;
		mag_s2  <= mag_s1;
		neg_s2  <= neg_s1;
		rsum_s2 <= rsum_s1;
		trig_s2 <= trig_s1;
		ma_s2   <= ma_s1;
		mb_s2   <= mb_s1;
	end

	// ---- stage 3: squared distance and overlap compare, seeds the root
	sq_t             sqp [0:CW];
	logic [CW:0]     sq_vld;
	logic [DW-1:0]   dist_c;
	logic            ovl_c;

	assign dist_c = DW'(sq_s2[0]) + DW'(sq_s2[1]) + DW'(sq_s2[2]);
	assign ovl_c  = dist_c <= DW'(rsq_s2);

	always_ff @(posedge clk) begin
		sqp[0].c.ovl  <= ovl_c;
		sqp[0].c.act  <= ovl_c & ~trig_s2 & (ma_s2 | mb_s2);
		sqp[0].c.ma   <= ma_s2;
		sqp[0].c.mb   <= mb_s2;
		sqp[0].c.neg  <= neg_s2;
		for (int i = 0; i < 3; i++) begin
			// mag never exceeds the root when the pair overlaps
			sqp[0].c.mag[i] <= mag_s2[i][CW-1:0];
		end
		sqp[0].c.rsum <= rsum_s2;
		sqp[0].rad    <= dist_c[2*CW-1:0];
		sqp[0].rem    <= '0;
		sqp[0].root   <= '0;
	end

	// ---- square root, one root bit per stage
	for (genvar k = 0; k < CW; k++) begin : g_sqrt
		logic [REMW+1:0] rn, tr;
		sq_t             nx;
		always_comb begin
			nx       = sqp[k];
			rn       = {sqp[k].rem, sqp[k].rad[2*CW-1 -: 2]};
			tr       = {1'b0, sqp[k].root, 2'b01};
			nx.rad   = {sqp[k].rad[2*CW-3:0], 2'b00};
			if (rn >= tr) begin
				nx.rem  = REMW'(rn - tr);
				nx.root = {sqp[k].root[CW-2:0], 1'b1};
			end else begin
				nx.rem  = REMW'(rn);
				nx.root = {sqp[k].root[CW-2:0], 1'b0};
			end
		end
		always_ff @(posedge clk) begin
			sqp[k+1] <= nx;
		end
	end

	// ---- push length; drop the push for coincident centers
	ctl_t          c_p, c_nx;
	logic [CW-1:0] len_p, push_p;
	logic          vld_p;

	always_comb begin
		c_nx     = sqp[CW].c;
		c_nx.act = sqp[CW].c.act & (sqp[CW].root != '0);
	end

	always_ff @(posedge clk) begin
		c_p     <= c_nx;
		len_p   <= sqp[CW].root;
		push_p  <= sqp[CW].c.rsum - sqp[CW].root;
	end

	// ---- magnitude times push, seeds the dividers
	dv_t        dvp [0:CW];
	logic [CW:0] dv_vld;
	logic [2:0][2*CW-1:0] prod_c;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			prod_c[i] = c_p.mag[i] * push_p;
		end
	end

	always_ff @(posedge clk) begin
		dvp[0].c   <= c_p;
		dvp[0].len <= len_p;
		for (int i = 0; i < 3; i++) begin
			dvp[0].rem[i] <= prod_c[i][2*CW-1:CW];
			dvp[0].num[i] <= prod_c[i][CW-1:0];
			dvp[0].q[i]   <= '0;
		end
	end

	// ---- restoring division, one quotient bit per stage on all three axes
	for (genvar k = 0; k < CW; k++) begin : g_div
		dv_t nx;
		logic [2:0][CW:0] rn;
		always_comb begin
			nx = dvp[k];
			for (int i = 0; i < 3; i++) begin
				rn[i]     = {dvp[k].rem[i], dvp[k].num[i][CW-1]};
				nx.num[i] = {dvp[k].num[i][CW-2:0], 1'b0};
				if (rn[i] >= {1'b0, dvp[k].len}) begin
					nx.rem[i] = CW'(rn[i] - {1'b0, dvp[k].len});
					nx.q[i]   = {dvp[k].q[i][CW-2:0], 1'b1};
				end else begin
					nx.rem[i] = rn[i][CW-1:0];
					nx.q[i]   = {dvp[k].q[i][CW-2:0], 1'b0};
				end
			end
		end
		always_ff @(posedge clk) begin
			dvp[k+1] <= nx;
		end
	end

	// ---- sign, split and saturate into the output register
	logic [2:0][CW-1:0] sa_c, sb_c;
	dv_t                fin;

	assign fin = dvp[CW];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sa_c[i] = '0;
			sb_c[i] = '0;
			if (fin.c.act) begin
				if (fin.c.ma && fin.c.mb) begin
					sa_c[i] = sat_pack({1'b0, fin.q[i][CW-1:1]}, fin.c.neg[i]);
					sb_c[i] = sat_pack({1'b0, fin.q[i][CW-1:1]}, ~fin.c.neg[i]);
				end else if (fin.c.ma) begin
					sa_c[i] = sat_pack(fin.q[i], fin.c.neg[i]);
				end else begin
					sb_c[i] = sat_pack(fin.q[i], ~fin.c.neg[i]);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		result.overlap   <= fin.c.ovl;
		result.shift_a_x <= sa_c[0];
		result.shift_a_y <= sa_c[1];
		result.shift_a_z <= sa_c[2];
		result.shift_b_x <= sb_c[0];
		result.shift_b_y <= sb_c[1];
		result.shift_b_z <= sb_c[2];
	end

	// ---- valid bits travel beside the data; reset clears them
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			sq_vld <= '0;
			vld_p  <= 1'b0;
			dv_vld <= '0;
			done   <= 1'b0;
		end else begin
			vld_s1 <= start & ~busy;
			vld_s2 <= vld_s1;
			sq_vld <= {sq_vld[CW-1:0], vld_s2};
			vld_p  <= sq_vld[CW];
			dv_vld <= {dv_vld[CW-1:0], vld_p};
			done   <= dv_vld[CW];
		end
	end

	// ---- checks
	a_no_push_without_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		done && !result.overlap |-> (result.shift_a_x == '0) && (result.shift_b_x == '0)
			&& (result.shift_a_y == '0) && (result.shift_b_z == '0))
		else $error("push reported without overlap");

	a_done_follows_entry: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(vld_s1, 2*CW+5))
		else $error("result strobe without an entering pair");

	a_single_mover: assert property (@(posedge clk) disable iff (!arst_n)
		dv_vld[CW] && fin.c.act && !fin.c.mb |=> (result.shift_b_x == '0)
			&& (result.shift_b_y == '0) && (result.shift_b_z == '0))
		else $error("fixed sphere B was pushed");

endmodule
